>>> sv/ncp_pkg.sv
// Shared constants for the normalized cross product core.
`timescale 1ns / 1ps
package ncp_pkg;
    localparam int IN_WIDTH_DEF  = 16;
    localparam int FRAC_BITS_DEF = 14;
    localparam int OUT_W         = 16;
endpackage

>>> sv/ncp_sqrt_cell.sv
// One bit step of the pipelined integer square root chain.
`timescale 1ns / 1ps
module ncp_sqrt_cell #(
    parameter int QW = 33,
    parameter int SW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  logic [2*QW-1:0] x_in,
    input  logic [QW+1:0]   rem_in,
    input  logic [QW-1:0]   root_in,
    input  logic [SW-1:0]   side_in,
    output logic            valid_out,
    output logic [2*QW-1:0] x_out,
    output logic [QW+1:0]   rem_out,
    output logic [QW-1:0]   root_out,
    output logic [SW-1:0]   side_out
);
    localparam int XW = 2 * QW;

    logic            valid_reg;
    logic [XW-1:0]   x_reg, x_next;
    logic [QW+1:0]   rem_reg, rem_next;
    logic [QW-1:0]   root_reg, root_next;
    logic [SW-1:0]   side_reg;
    logic [QW+3:0]   rem_t, trial, diff;
    logic            ge;

    always_comb
    begin
        rem_t     = {rem_in, x_in[XW-1 -: 2]};
        trial     = {2'b00, root_in, 2'b01};
        diff      = rem_t - trial;
        ge        = (rem_t >= trial);
        rem_next  = ge ? diff[QW+1:0] : rem_t[QW+1:0];
        root_next = {root_in[QW-2:0], ge};
        x_next    = {x_in[XW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;
endmodule

>>> sv/ncp_div_cell.sv
// One quotient bit step of the pipelined restoring divider chain.
`timescale 1ns / 1ps
module ncp_div_cell #(
    parameter int DW    = 33,
    parameter int QB    = 15,
    parameter int SW    = 1,
    parameter bit SHIFT = 1'b1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_in,
    input  logic [DW:0]   rem_in,
    input  logic [DW-1:0] d_in,
    input  logic [QB-1:0] q_in,
    input  logic [SW-1:0] side_in,
    output logic          valid_out,
    output logic [DW:0]   rem_out,
    output logic [DW-1:0] d_out,
    output logic [QB-1:0] q_out,
    output logic [SW-1:0] side_out
);
    logic          valid_reg;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] d_reg;
    logic [QB-1:0] q_reg, q_next;
    logic [SW-1:0] side_reg;
    logic [DW+1:0] r_t, dx, diff;
    logic          ge;

    always_comb
    begin
        r_t      = SHIFT ? {rem_in, 1'b0} : {1'b0, rem_in};
        dx       = {2'b00, d_in};
        diff     = r_t - dx;
        ge       = (r_t >= dx);
        rem_next = ge ? diff[DW:0] : r_t[DW:0];
        q_next   = {q_in[QB-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            d_reg    <= d_in;
            q_reg    <= q_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign d_out     = d_reg;
    assign q_out     = q_reg;
    assign side_out  = side_reg;
endmodule

>>> sv/normalized_cross_product_core.sv
// Top level: pipelined normalized 3D cross product in Q1.FRAC_BITS.
// Usage:
//   Input channel (in_valid/in_ready) carries one item: vectors a and b as
//   signed IN_WIDTH components. Output channel (out_valid/out_ready) carries
//   nx, ny, nz (signed Q1.FRAC_BITS, 16 bits) and is_zero.
//   Pipeline: four arithmetic stages (products, differences, squares,
//   sum), one cell per root bit of the square root chain, one cell per
//   quotient bit of the three divider chains, then the output register.
//   Throughput: one item per cycle while not stalled; every cell is a pipeline register.
//   Stall: the whole pipe advances when the output register is empty or
//   being taken; while the receiver holds out_ready low with a result
//   waiting, in_ready drops and all items in flight hold their place.
//   Reset: clears all valid bits; the pipe comes up empty and ready.
//   A zero cross product (parallel or zero vectors) gives is_zero = 1 with
//   all components zero.
`timescale 1ns / 1ps
module normalized_cross_product_core #(
    parameter int IN_WIDTH  = ncp_pkg::IN_WIDTH_DEF,
    parameter int FRAC_BITS = ncp_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [IN_WIDTH-1:0]        ax,
    input  logic [IN_WIDTH-1:0]        ay,
    input  logic [IN_WIDTH-1:0]        az,
    input  logic [IN_WIDTH-1:0]        bx,
    input  logic [IN_WIDTH-1:0]        by,
    input  logic [IN_WIDTH-1:0]        bz,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ncp_pkg::OUT_W-1:0]  nx,
    output logic [ncp_pkg::OUT_W-1:0]  ny,
    output logic [ncp_pkg::OUT_W-1:0]  nz,
    output logic                       is_zero
);
    localparam int W   = IN_WIDTH;
    localparam int PW  = 2 * W;           // product / magnitude width
    localparam int CW  = 2 * W + 1;       // cross component width
    localparam int QW  = 2 * W + 1;       // root bits
    localparam int XW  = 2 * QW;          // radicand width
    localparam int QB  = FRAC_BITS + 1;   // quotient bits
    localparam int SSW = 3 * PW + 3;      // side data through the root chain
    localparam int OW  = ncp_pkg::OUT_W;
    localparam int NW  = ((QB > OW) ? QB : OW) + 1;

    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: products
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [PW-1:0] p_reg [6];
    logic signed [PW-1:0] p_next [6];

    always_comb
    begin
        p_next[0] = $signed(ay) * $signed(bz);
        p_next[1] = $signed(az) * $signed(by);
        p_next[2] = $signed(az) * $signed(bx);
        p_next[3] = $signed(ax) * $signed(bz);
        p_next[4] = $signed(ax) * $signed(by);
        p_next[5] = $signed(ay) * $signed(bx);
    end

    // stage 2: cross components, magnitudes and signs
    logic signed [CW-1:0] c_next [3];
    logic [PW-1:0]        m_reg [3];
    logic [PW-1:0]        m_next [3];
    logic [2:0]           sg_reg, sg_next;
    // stage 3: squares; stage 4: sum
    logic [2*PW-1:0]      sq_reg [3];
    logic [PW-1:0]        m3_reg [3];
    logic [2:0]           sg3_reg;
    logic [XW-1:0]        s_reg, s_next;
    logic [SSW-1:0]       side4_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c_next[k] = $signed({p_reg[2*k][PW-1], p_reg[2*k]})
                      - $signed({p_reg[2*k+1][PW-1], p_reg[2*k+1]});
            sg_next[k] = c_next[k][CW-1];
            m_next[k]  = sg_next[k] ? PW'(-c_next[k]) : PW'(c_next[k]);
        end
        s_next = XW'(sq_reg[0]) + XW'(sq_reg[1]) + XW'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 6; k++)
            begin
                p_reg[k] <= p_next[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                m_reg[k]  <= m_next[k];
                sq_reg[k] <= m_reg[k] * m_reg[k];
                m3_reg[k] <= m_reg[k];
            end
            sg_reg    <= sg_next;
            sg3_reg   <= sg_reg;
            s_reg     <= s_next;
            side4_reg <= {sg3_reg, m3_reg[2], m3_reg[1], m3_reg[0]};
        end
    end

    // square root chain: one cell per root bit
    logic           rv  [QW+1];
    logic [XW-1:0]  rx  [QW+1];
    logic [QW+1:0]  rr  [QW+1];
    logic [QW-1:0]  rq  [QW+1];
    logic [SSW-1:0] rs  [QW+1];

    assign rv[0] = v4_reg;
    assign rx[0] = s_reg;
    assign rr[0] = '0;
    assign rq[0] = '0;
    assign rs[0] = side4_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_sqrt
        ncp_sqrt_cell #(.QW(QW), .SW(SSW)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(rv[i]), .x_in(rx[i]), .rem_in(rr[i]),
            .root_in(rq[i]), .side_in(rs[i]),
            .valid_out(rv[i+1]), .x_out(rx[i+1]), .rem_out(rr[i+1]),
            .root_out(rq[i+1]), .side_out(rs[i+1])
        );
    end

    // three divider chains: trunc(|c| * 2^FRAC_BITS / d)
    logic          dv  [3][QB+1];
    logic [QW:0]   dr  [3][QB+1];
    logic [QW-1:0] dd  [3][QB+1];
    logic [QB-1:0] dq  [3][QB+1];
    logic          ds  [3][QB+1];

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        assign dv[k][0] = rv[QW];
        assign dr[k][0] = (QW+1)'(rs[QW][k*PW +: PW]);
        assign dd[k][0] = rq[QW];
        assign dq[k][0] = '0;
        assign ds[k][0] = rs[QW][3*PW+k];
        for (genvar j = 0; j < QB; j++)
        begin : g_step
            ncp_div_cell #(.DW(QW), .QB(QB), .SW(1), .SHIFT(j != 0)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en),
                .valid_in(dv[k][j]), .rem_in(dr[k][j]), .d_in(dd[k][j]),
                .q_in(dq[k][j]), .side_in(ds[k][j]),
                .valid_out(dv[k][j+1]), .rem_out(dr[k][j+1]), .d_out(dd[k][j+1]),
                .q_out(dq[k][j+1]), .side_out(ds[k][j+1])
            );
        end
    end

    // output register
    logic [OW-1:0] n_reg [3];
    logic [OW-1:0] n_next [3];
    logic          zero_reg, zero_next;
    logic [NW-1:0] qx;

    always_comb
    begin
        zero_next = (dd[0][QB] == '0);
        qx        = '0;
        for (int k = 0; k < 3; k++)
        begin
            qx        = NW'(dq[k][QB]);
            qx        = ds[k][QB] ? -qx : qx;
            n_next[k] = zero_next ? '0 : qx[OW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv[0][QB] & dv[1][QB] & dv[2][QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                n_reg[k] <= n_next[k];
            end
            zero_reg <= zero_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign nx        = n_reg[0];
    assign ny        = n_reg[1];
    assign nz        = n_reg[2];
    assign is_zero   = zero_reg;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted item did not enter the pipe");
    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_zero |-> nx == '0 && ny == '0 && nz == '0)
        else $error("zero magnitude with nonzero component");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_ready |=> out_valid && $stable(nx) && $stable(is_zero))
        else $error("stalled result lost");
    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        dv[0][QB] == dv[1][QB] && dv[1][QB] == dv[2][QB])
        else $error("divider lanes out of step");
`endif
endmodule
